// ===== src/bzr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier evaluator package
// Shared widths, constants, register indexes and transfer types.
// ----------------------------------------------------------------------------
package bzr_pkg;

    localparam int COORD_BITS    = 20;
    localparam int T_FRAC_BITS   = 16;
    localparam int DIR_FRAC_BITS = 15;
    localparam int AXES          = 3;

    localparam int T_BITS    = T_FRAC_BITS + 2;
    localparam int W_BITS    = T_FRAC_BITS + 1;
    localparam int PROD_BITS = 2 * W_BITS;
    localparam int P3_BITS   = PROD_BITS + 2;
    localparam int PW_BITS   = W_BITS + 1 + COORD_BITS;
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int PD_BITS   = W_BITS + 1 + DIFF_BITS;
    localparam int ACC_BITS  = PW_BITS + 2;
    localparam int DV_BITS   = PD_BITS + 2;
    localparam int RND_BITS  = ACC_BITS - T_FRAC_BITS;

    localparam int NORM_BITS = 30;
    localparam int LEAD_BITS = 6;
    localparam int GRP_BITS  = 8;
    localparam int GROUPS    = (DV_BITS + GRP_BITS - 1) / GRP_BITS;
    localparam int SQ_BITS   = 2 * NORM_BITS + 2;
    localparam int LEN_BITS  = NORM_BITS + 1;
    localparam int Q_BITS    = DIR_FRAC_BITS + 1;
    localparam int NUM_BITS  = NORM_BITS + DIR_FRAC_BITS + 1;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;

    localparam int CFG_IDX_BITS = 8;
    localparam int CFG_BITS     = 3 * COORD_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_POINT0 = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_POINT1 = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_POINT2 = 8'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_POINT3 = 8'd3;

    localparam logic [W_BITS-1:0] T_ONE = W_BITS'(1) << T_FRAC_BITS;
    localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [Q_BITS-1:0] DIR_MAX = {1'b0, {(Q_BITS-1){1'b1}}};

    typedef logic [3:0][CFG_BITS-1:0] t_points;

    // Bernstein weights for position and the reduced derivative weights
    typedef struct packed {
        logic [W_BITS-1:0] w0;
        logic [W_BITS-1:0] w1;
        logic [W_BITS-1:0] w2;
        logic [W_BITS-1:0] w3;
        logic [W_BITS-1:0] c0;
        logic [W_BITS-1:0] c1;
        logic [W_BITS-1:0] c2;
    } t_weights;

    // Data that rides alongside the square root and divide pipelines
    typedef struct packed {
        logic [AXES-1:0][COORD_BITS-1:0] pos;
        logic [AXES-1:0]                 neg;
        logic                            zero;
        logic [AXES-1:0][NORM_BITS-1:0]  mag;
    } t_side;

endpackage

// ===== src/cubic_bezier_position_tangent.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Bezier position and tangent
// Evaluate a 3D cubic Bezier curve: position and unit tangent per parameter.
// ----------------------------------------------------------------------------
// Load the four control points through the configuration channel (index 0..3,
// x in bits 19:0, y in 39:20, z in 59:40, signed Q12.8; other indexes are
// dropped) while the block is idle, then stream curve parameters in Q2.16;
// values outside 0..1 clamp to the ends. Each transfer in gives one transfer
// out carrying the position in Q12.8 and the unit tangent in Q1.15 (zero when
// the derivative vanishes). The block takes one parameter per clock and
// delivers one result per clock when the output is not stalled. Each
// parameter passes through weight generation, the eight-entry queue, the
// sums and normalization, the bit-per-stage square root, the bit-per-stage
// divider and the output register. A stall on the output holds the whole
// evaluation pipeline; the front end keeps accepting until the queue credit
// runs out.
// ----------------------------------------------------------------------------
module cubic_bezier_position_tangent import bzr_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [CFG_BITS-1:0]          i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [T_BITS-1:0]     i_param_t,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [COORD_BITS-1:0] o_pos_x,
    output logic signed [COORD_BITS-1:0] o_pos_y,
    output logic signed [COORD_BITS-1:0] o_pos_z,
    output logic signed [Q_BITS-1:0]     o_dir_x,
    output logic signed [Q_BITS-1:0]     o_dir_y,
    output logic signed [Q_BITS-1:0]     o_dir_z
);

    t_points              r_pts;
    logic                 f_valid, q_valid, q_pop;
    t_weights             f_weights, q_weights;
    logic [1:0]           f_inflight;
    logic [FIFO_AW:0]     q_count;
    logic [FIFO_AW+1:0]   credit_used;
    logic [AXES-1:0][COORD_BITS-1:0] pos;
    logic [AXES-1:0][Q_BITS-1:0]     dir;

    // configuration registers: always ready, unknown indexes dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pts <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_POINT0: r_pts[0] <= i_cfg_data;
                REG_POINT1: r_pts[1] <= i_cfg_data;
                REG_POINT2: r_pts[2] <= i_cfg_data;
                REG_POINT3: r_pts[3] <= i_cfg_data;
                default:    r_pts    <= r_pts;
            endcase
        end
    end

    // credit: items in the front end plus items queued never exceed the queue
    assign credit_used = (FIFO_AW+2)'(q_count) + (FIFO_AW+2)'(f_inflight);
    assign o_in_stall  = (credit_used >= (FIFO_AW+2)'(FIFO_DEPTH));

    bzr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid && !o_in_stall),
        .i_param_t  (i_param_t),
        .o_valid    (f_valid),
        .o_weights  (f_weights),
        .o_inflight (f_inflight)
    );

    bzr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_weights),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_weights),
        .o_count (q_count)
    );

    bzr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pts     (r_pts),
        .i_valid   (q_valid),
        .i_weights (q_weights),
        .o_pop     (q_pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_pos     (pos),
        .o_dir     (dir)
    );

    assign o_pos_x = $signed(pos[0]);
    assign o_pos_y = $signed(pos[1]);
    assign o_pos_z = $signed(pos[2]);
    assign o_dir_x = $signed(dir[0]);
    assign o_dir_y = $signed(dir[1]);
    assign o_dir_z = $signed(dir[2]);

endmodule

// ===== src/bzr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier front end
// Clamp the curve parameter and build the weights in three stages.
// ----------------------------------------------------------------------------
module bzr_front import bzr_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic signed [T_BITS-1:0] i_param_t,
    output logic                     o_valid,
    output t_weights                 o_weights,
    output logic [1:0]               o_inflight
);

    localparam logic [PROD_BITS-1:0] HALF  = PROD_BITS'(1) << (T_FRAC_BITS - 1);
    localparam logic [P3_BITS-1:0]   HALF3 = P3_BITS'(1) << (T_FRAC_BITS - 1);

    logic              r1_v, r2_v, r3_v;
    logic [W_BITS-1:0] r1_t, r1_u;
    logic [W_BITS-1:0] r2_t, r2_u, r2_t2, r2_u2, r2_c1;
    t_weights          r3_w;

    logic [W_BITS-1:0]    n1_t;
    logic [PROD_BITS-1:0] tt, uu, ut, t2t, u2u, u2t, ut2;
    t_weights             n3_w;

    always_comb begin
        if (i_param_t[T_BITS-1]) begin
            n1_t = '0;
        end else if (i_param_t[T_FRAC_BITS] && (|i_param_t[T_FRAC_BITS-1:0])) begin
            n1_t = T_ONE;
        end else begin
            n1_t = i_param_t[W_BITS-1:0];
        end
    end

    assign tt = r1_t * r1_t;
    assign uu = r1_u * r1_u;
    assign ut = r1_u * r1_t;

    assign t2t = r2_t2 * r2_t;
    assign u2u = r2_u2 * r2_u;
    assign u2t = r2_u2 * r2_t;
    assign ut2 = r2_u * r2_t2;

    always_comb begin
        n3_w.w0 = W_BITS'((u2u + HALF) >> T_FRAC_BITS);
        n3_w.w1 = W_BITS'((P3_BITS'(u2t) + (P3_BITS'(u2t) << 1) + HALF3) >> T_FRAC_BITS);
        n3_w.w2 = W_BITS'((P3_BITS'(ut2) + (P3_BITS'(ut2) << 1) + HALF3) >> T_FRAC_BITS);
        n3_w.w3 = W_BITS'((t2t + HALF) >> T_FRAC_BITS);
        n3_w.c0 = r2_u2;
        n3_w.c1 = r2_c1;
        n3_w.c2 = r2_t2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_t  <= n1_t;
        r1_u  <= T_ONE - n1_t;
        r2_t  <= r1_t;
        r2_u  <= r1_u;
        r2_t2 <= W_BITS'((tt + HALF) >> T_FRAC_BITS);
        r2_u2 <= W_BITS'((uu + HALF) >> T_FRAC_BITS);
        r2_c1 <= W_BITS'((ut + (HALF >> 1)) >> (T_FRAC_BITS - 1));
        r3_w  <= n3_w;
    end

    assign o_valid    = r3_v;
    assign o_weights  = r3_w;
    assign o_inflight = 2'(r1_v) + 2'(r2_v) + 2'(r3_v);

endmodule

// ===== src/bzr_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier weight queue
// Short queue that decouples the weight front end from the evaluation back end.
// ----------------------------------------------------------------------------
module bzr_fifo import bzr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_weights           i_data,
    input  logic               i_pop,
    output logic               o_valid,
    output t_weights           o_data,
    output logic [FIFO_AW:0]   o_count
);

    t_weights             r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wp, r_rp;
    logic [FIFO_AW:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (FIFO_AW+1)'(i_push) - (FIFO_AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_cnt;

endmodule

// ===== src/bzr_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier square root
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module bzr_isqrt import bzr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [SQ_BITS-1:0]  i_x,
    input  t_side               i_side,
    output logic                o_valid,
    output logic [LEN_BITS-1:0] o_len,
    output t_side               o_side
);

    logic                r_v    [LEN_BITS];
    logic [SQ_BITS-1:0]  r_rem  [LEN_BITS];
    logic [LEN_BITS-1:0] r_root [LEN_BITS];
    t_side               r_sd   [LEN_BITS];

    logic                c_v    [LEN_BITS];
    logic [SQ_BITS-1:0]  c_rem  [LEN_BITS];
    logic [LEN_BITS-1:0] c_root [LEN_BITS];
    t_side               c_sd   [LEN_BITS];
    logic [SQ_BITS-1:0]  c_try  [LEN_BITS];
    logic [SQ_BITS-1:0]  n_rem  [LEN_BITS];
    logic [LEN_BITS-1:0] n_root [LEN_BITS];

    always_comb begin
        for (int k = 0; k < LEN_BITS; k++) begin
            if (k == 0) begin
                c_v[k]    = i_valid;
                c_rem[k]  = i_x;
                c_root[k] = '0;
                c_sd[k]   = i_side;
            end else begin
                c_v[k]    = r_v[k-1];
                c_rem[k]  = r_rem[k-1];
                c_root[k] = r_root[k-1];
                c_sd[k]   = r_sd[k-1];
            end
            // try the next bit: (root + 2^b)^2 - root^2
            c_try[k] = (SQ_BITS'(c_root[k]) << (LEN_BITS - k))
                     | (SQ_BITS'(1) << (2 * (LEN_BITS - 1 - k)));
            if (c_rem[k] >= c_try[k]) begin
                n_rem[k]  = c_rem[k] - c_try[k];
                n_root[k] = c_root[k] | (LEN_BITS'(1) << (LEN_BITS - 1 - k));
            end else begin
                n_rem[k]  = c_rem[k];
                n_root[k] = c_root[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LEN_BITS; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            for (int k = 0; k < LEN_BITS; k++) begin
                r_v[k] <= c_v[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < LEN_BITS; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_sd[k]   <= c_sd[k];
            end
        end
    end

    assign o_valid = r_v[LEN_BITS-1];
    assign o_len   = r_root[LEN_BITS-1];
    assign o_side  = r_sd[LEN_BITS-1];

endmodule

// ===== src/bzr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier tangent divider
// Three-lane pipelined rounded division of the scaled magnitudes by the length.
// ----------------------------------------------------------------------------
module bzr_div import bzr_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [LEN_BITS-1:0]           i_len,
    input  t_side                         i_side,
    output logic                          o_valid,
    output logic [AXES-1:0][Q_BITS-1:0]   o_quo,
    output t_side                         o_side
);

    logic                r_v   [Q_BITS];
    logic [LEN_BITS-1:0] r_len [Q_BITS];
    t_side               r_sd  [Q_BITS];
    logic [LEN_BITS-1:0] r_rm  [Q_BITS][AXES];
    logic [Q_BITS-1:0]   r_nl  [Q_BITS][AXES];
    logic [Q_BITS-1:0]   r_q   [Q_BITS][AXES];

    logic                c_v   [Q_BITS];
    logic [LEN_BITS-1:0] c_len [Q_BITS];
    t_side               c_sd  [Q_BITS];
    logic [LEN_BITS-1:0] c_rm  [Q_BITS][AXES];
    logic [Q_BITS-1:0]   c_nl  [Q_BITS][AXES];
    logic [Q_BITS-1:0]   c_q   [Q_BITS][AXES];
    logic [LEN_BITS:0]   c_rr  [Q_BITS][AXES];
    logic [LEN_BITS-1:0] n_rm  [Q_BITS][AXES];
    logic [Q_BITS-1:0]   n_q   [Q_BITS][AXES];
    logic [NUM_BITS-1:0] num   [AXES];

    always_comb begin
        // numerator mag * 2^DIR_FRAC_BITS + len/2; its top part is below len
        for (int a = 0; a < AXES; a++) begin
            num[a] = (NUM_BITS'(i_side.mag[a]) << DIR_FRAC_BITS)
                   + NUM_BITS'(i_len >> 1);
        end
        for (int k = 0; k < Q_BITS; k++) begin
            if (k == 0) begin
                c_v[k]   = i_valid;
                c_len[k] = i_len;
                c_sd[k]  = i_side;
            end else begin
                c_v[k]   = r_v[k-1];
                c_len[k] = r_len[k-1];
                c_sd[k]  = r_sd[k-1];
            end
            for (int a = 0; a < AXES; a++) begin
                if (k == 0) begin
                    c_rm[k][a] = LEN_BITS'(num[a] >> Q_BITS);
                    c_nl[k][a] = num[a][Q_BITS-1:0];
                    c_q[k][a]  = '0;
                end else begin
                    c_rm[k][a] = r_rm[k-1][a];
                    c_nl[k][a] = r_nl[k-1][a];
                    c_q[k][a]  = r_q[k-1][a];
                end
                c_rr[k][a] = {c_rm[k][a], c_nl[k][a][Q_BITS-1-k]};
                if (c_rr[k][a] >= {1'b0, c_len[k]}) begin
                    n_rm[k][a] = LEN_BITS'(c_rr[k][a] - {1'b0, c_len[k]});
                    n_q[k][a]  = c_q[k][a] | (Q_BITS'(1) << (Q_BITS - 1 - k));
                end else begin
                    n_rm[k][a] = LEN_BITS'(c_rr[k][a]);
                    n_q[k][a]  = c_q[k][a];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < Q_BITS; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            for (int k = 0; k < Q_BITS; k++) begin
                r_v[k] <= c_v[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < Q_BITS; k++) begin
                r_len[k] <= c_len[k];
                r_sd[k]  <= c_sd[k];
                for (int a = 0; a < AXES; a++) begin
                    r_rm[k][a] <= n_rm[k][a];
                    r_nl[k][a] <= c_nl[k][a];
                    r_q[k][a]  <= n_q[k][a];
                end
            end
        end
    end

    assign o_valid = r_v[Q_BITS-1];
    assign o_side  = r_sd[Q_BITS-1];

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            o_quo[a] = r_q[Q_BITS-1][a];
        end
    end

endmodule

// ===== src/bzr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier back end
// Position sums, derivative, normalization, length and unit tangent.
// ----------------------------------------------------------------------------
module bzr_back import bzr_pkg::*; (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_points                            i_pts,
    input  logic                               i_valid,
    input  t_weights                           i_weights,
    output logic                               o_pop,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [AXES-1:0][COORD_BITS-1:0]    o_pos,
    output logic [AXES-1:0][Q_BITS-1:0]        o_dir
);

    localparam logic [ACC_BITS-1:0] PHALF = ACC_BITS'(1) << (T_FRAC_BITS - 1);
    localparam logic [LEAD_BITS-1:0] NTOP = LEAD_BITS'(NORM_BITS - 1);

    logic en;

    logic signed [DIFF_BITS-1:0] r_dif [3][AXES];

    logic                        r1_v;
    logic signed [PW_BITS-1:0]   r1_pw [AXES][4];
    logic signed [PD_BITS-1:0]   r1_pd [AXES][3];
    logic                        r2_v;
    logic signed [ACC_BITS-1:0]  r2_acc [AXES];
    logic signed [DV_BITS-1:0]   r2_dv  [AXES];
    logic                        r3_v, r4_v, r5_v, r6_v, r7_v, r8_v;
    logic [AXES-1:0][COORD_BITS-1:0] r3_pos, r4_pos, r5_pos, r6_pos, r7_pos, r8_pos;
    logic [AXES-1:0]             r3_neg, r4_neg, r5_neg, r6_neg, r7_neg, r8_neg;
    logic [DV_BITS-1:0]          r3_mag [AXES];
    logic [DV_BITS-1:0]          r4_mag [AXES];
    logic [DV_BITS-1:0]          r5_mag [AXES];
    logic [GROUPS-1:0]           r4_gnz;
    logic [2:0]                  r4_glo [GROUPS];
    logic [LEAD_BITS-1:0]        r5_lead;
    logic                        r5_zero, r6_zero, r7_zero, r8_zero;
    logic [AXES-1:0][NORM_BITS-1:0] r6_m, r7_m, r8_m;
    logic [2*NORM_BITS-1:0]      r7_sq [AXES];
    logic [SQ_BITS-1:0]          r8_sum;

    logic                        r_ov;
    logic [AXES-1:0][COORD_BITS-1:0] r_pos;
    logic [AXES-1:0][Q_BITS-1:0] r_dir;

    logic signed [COORD_BITS-1:0] crd [4][AXES];
    logic signed [W_BITS:0]       ws [4];
    logic signed [W_BITS:0]       cs [3];
    logic [ACC_BITS-1:0]          pabs [AXES];
    logic [RND_BITS-1:0]          prnd [AXES];
    logic [AXES-1:0][COORD_BITS-1:0] n3_pos;
    logic [DV_BITS-1:0]           n3_mag [AXES];
    logic [GROUPS*GRP_BITS-1:0]   orv;
    logic [GROUPS-1:0]            n4_gnz;
    logic [2:0]                   n4_glo [GROUPS];
    logic [LEAD_BITS-1:0]         n5_lead;
    logic                         n5_zero;
    logic [AXES-1:0][NORM_BITS-1:0] n6_m;
    t_side                        sq_side, dv_side_in, dv_side;
    logic                         sq_v, dq_v;
    logic [LEN_BITS-1:0]          sq_len;
    logic [AXES-1:0][Q_BITS-1:0]  quo;
    logic [AXES-1:0][Q_BITS-1:0]  n_dir;
    logic [Q_BITS-1:0]            qs [AXES];

    // advance the whole back end unless the finished result is held
    assign en    = !(r_ov && i_stall);
    assign o_pop = en && i_valid;

    always_comb begin
        for (int p = 0; p < 4; p++) begin
            for (int a = 0; a < AXES; a++) begin
                crd[p][a] = $signed(i_pts[p][a*COORD_BITS +: COORD_BITS]);
            end
        end
        ws[0] = $signed({1'b0, i_weights.w0});
        ws[1] = $signed({1'b0, i_weights.w1});
        ws[2] = $signed({1'b0, i_weights.w2});
        ws[3] = $signed({1'b0, i_weights.w3});
        cs[0] = $signed({1'b0, i_weights.c0});
        cs[1] = $signed({1'b0, i_weights.c1});
        cs[2] = $signed({1'b0, i_weights.c2});
    end

    // control point differences follow the registers; the user must change them only while idle (not enforced here)
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            for (int a = 0; a < AXES; a++) begin
                r_dif[k][a] <= DIFF_BITS'(crd[k+1][a]) - DIFF_BITS'(crd[k][a]);
            end
        end
    end

    // rounding and saturation of the position, and magnitudes of the derivative
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            pabs[a] = r2_acc[a][ACC_BITS-1] ? ACC_BITS'(-r2_acc[a]) : ACC_BITS'(r2_acc[a]);
            prnd[a] = RND_BITS'((pabs[a] + PHALF) >> T_FRAC_BITS);
            if (!r2_acc[a][ACC_BITS-1] && (prnd[a] > RND_BITS'(COORD_MAX))) begin
                n3_pos[a] = COORD_MAX;
            end else if (r2_acc[a][ACC_BITS-1] && (prnd[a] > RND_BITS'(COORD_MIN))) begin
                n3_pos[a] = COORD_MIN;
            end else if (r2_acc[a][ACC_BITS-1]) begin
                n3_pos[a] = COORD_BITS'(-prnd[a]);
            end else begin
                n3_pos[a] = COORD_BITS'(prnd[a]);
            end
            n3_mag[a] = r2_dv[a][DV_BITS-1] ? DV_BITS'(-r2_dv[a]) : DV_BITS'(r2_dv[a]);
        end
    end

    // leading one of the largest magnitude, first per byte group, then the normalizing shift
    always_comb begin
        orv = (GROUPS*GRP_BITS)'(r3_mag[0] | r3_mag[1] | r3_mag[2]);
        for (int g = 0; g < GROUPS; g++) begin
            n4_gnz[g] = |orv[g*GRP_BITS +: GRP_BITS];
            n4_glo[g] = '0;
            for (int i = 0; i < GRP_BITS; i++) begin
                if (orv[g*GRP_BITS + i]) begin
                    n4_glo[g] = 3'(i);
                end
            end
        end
        n5_lead = '0;
        n5_zero = 1'b1;
        for (int g = 0; g < GROUPS; g++) begin
            if (r4_gnz[g]) begin
                n5_lead = {3'(g), r4_glo[g]};
                n5_zero = 1'b0;
            end
        end
        for (int a = 0; a < AXES; a++) begin
            if (r5_lead >= NTOP) begin
                n6_m[a] = NORM_BITS'(r5_mag[a] >> (r5_lead - NTOP));
            end else begin
                n6_m[a] = NORM_BITS'(r5_mag[a] << (NTOP - r5_lead));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
            r8_v <= r7_v;
            r_ov <= dq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < AXES; a++) begin
                for (int k = 0; k < 4; k++) begin
                    r1_pw[a][k] <= PW_BITS'(ws[k]) * PW_BITS'(crd[k][a]);
                end
                for (int k = 0; k < 3; k++) begin
                    r1_pd[a][k] <= PD_BITS'(cs[k]) * PD_BITS'(r_dif[k][a]);
                end
                r2_acc[a] <= ACC_BITS'(r1_pw[a][0]) + ACC_BITS'(r1_pw[a][1])
                           + ACC_BITS'(r1_pw[a][2]) + ACC_BITS'(r1_pw[a][3]);
                r2_dv[a]  <= DV_BITS'(r1_pd[a][0]) + DV_BITS'(r1_pd[a][1])
                           + DV_BITS'(r1_pd[a][2]);
                r3_mag[a] <= n3_mag[a];
                r4_mag[a] <= r3_mag[a];
                r5_mag[a] <= r4_mag[a];
                r3_neg[a] <= r2_dv[a][DV_BITS-1];
                r7_sq[a]  <= (2*NORM_BITS)'(r6_m[a]) * (2*NORM_BITS)'(r6_m[a]);
            end
            for (int g = 0; g < GROUPS; g++) begin
                r4_glo[g] <= n4_glo[g];
            end
            r3_pos  <= n3_pos;
            r4_pos  <= r3_pos;
            r5_pos  <= r4_pos;
            r6_pos  <= r5_pos;
            r7_pos  <= r6_pos;
            r8_pos  <= r7_pos;
            r4_neg  <= r3_neg;
            r5_neg  <= r4_neg;
            r6_neg  <= r5_neg;
            r7_neg  <= r6_neg;
            r8_neg  <= r7_neg;
            r4_gnz  <= n4_gnz;
            r5_lead <= n5_lead;
            r5_zero <= n5_zero;
            r6_zero <= r5_zero;
            r7_zero <= r6_zero;
            r8_zero <= r7_zero;
            r6_m    <= n6_m;
            r7_m    <= r6_m;
            r8_m    <= r7_m;
            r8_sum  <= SQ_BITS'(r7_sq[0]) + SQ_BITS'(r7_sq[1]) + SQ_BITS'(r7_sq[2]);
            r_pos   <= dv_side.pos;
            r_dir   <= n_dir;
        end
    end

    always_comb begin
        sq_side.pos  = r8_pos;
        sq_side.neg  = r8_neg;
        sq_side.zero = r8_zero;
        sq_side.mag  = r8_m;
    end

    bzr_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r8_v),
        .i_x     (r8_sum),
        .i_side  (sq_side),
        .o_valid (sq_v),
        .o_len   (sq_len),
        .o_side  (dv_side_in)
    );

    bzr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_v),
        .i_len   (sq_len),
        .i_side  (dv_side_in),
        .o_valid (dq_v),
        .o_quo   (quo),
        .o_side  (dv_side)
    );

    // saturate, apply the sign, and force a zero tangent for a zero derivative
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            qs[a] = (quo[a] > DIR_MAX) ? DIR_MAX : quo[a];
            if (dv_side.zero) begin
                n_dir[a] = '0;
            end else if (dv_side.neg[a]) begin
                n_dir[a] = Q_BITS'(-qs[a]);
            end else begin
                n_dir[a] = qs[a];
            end
        end
    end

    assign o_valid = r_ov;
    assign o_pos   = r_pos;
    assign o_dir   = r_dir;

endmodule

// ===== bench/cubic_bezier_position_tangent_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Bezier position and tangent testbench
// Load control points, stream curve parameters under random idling and a long
// output hold-off, and compare every result against a fixed-point predictor.
// ----------------------------------------------------------------------------
import bzr_pkg::*;

typedef struct {
    logic signed [COORD_BITS-1:0] pos_x, pos_y, pos_z;
    logic signed [Q_BITS-1:0]     dir_x, dir_y, dir_z;
} t_curve_sample;

class curve_scoreboard;
    logic [CFG_BITS-1:0] points [4];
    t_curve_sample       pending [$];
    int                  errors;

    function new();
        for (int i = 0; i < 4; i++) points[i] = '0;
        errors = 0;
    endfunction

    function void write_point(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
        if (idx <= REG_POINT3) points[idx] = data;
    endfunction

    function longint coord(int pt, int axis);
        logic signed [COORD_BITS-1:0] c;
        c = points[pt][axis*COORD_BITS +: COORD_BITS];
        return longint'(c);
    endfunction

    function longint rnd(longint x);
        return (x + (64'sd1 <<< (T_FRAC_BITS-1))) >>> T_FRAC_BITS;
    endfunction

    function longint unsigned root(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Note an accepted parameter and queue the curve sample it produces
    function void note_param(logic signed [T_BITS-1:0] pt);
        longint t, u, t2, t3, u2, u3, acc, p, mx, one;
        longint w [4];
        longint c [3];
        longint dv [3];
        longint unsigned mag [3];
        longint unsigned sq, len, q;
        longint pos [3];
        longint dir [3];
        t_curve_sample s;
        one = 64'sd1 <<< T_FRAC_BITS;
        t = longint'(pt);
        if (t < 0) t = 0;
        else if (t > one) t = one;
        u = one - t;
        t2 = rnd(t*t); t3 = rnd(t2*t); u2 = rnd(u*u); u3 = rnd(u2*u);
        w[0] = u3; w[1] = rnd(3*u2*t); w[2] = rnd(3*u*t2); w[3] = t3;
        c[0] = u2; c[1] = rnd(2*u*t); c[2] = t2;
        mx = 0;
        for (int a = 0; a < 3; a++) begin
            acc = 0;
            for (int k = 0; k < 4; k++) acc += w[k] * coord(k, a);
            p = (acc < 0) ? -rnd(-acc) : rnd(acc);
            if (p > 524287) p = 524287;
            if (p < -524288) p = -524288;
            pos[a] = p;
            dv[a] = 0;
            for (int k = 0; k < 3; k++) dv[a] += c[k] * (coord(k+1, a) - coord(k, a));
            mag[a] = (dv[a] < 0) ? -dv[a] : dv[a];
            if (mag[a] > mx) mx = mag[a];
            dir[a] = 0;
        end
        if (mx != 0) begin
            while (mx >= (64'sd1 <<< 30)) begin
                mx >>= 1;
                for (int a = 0; a < 3; a++) mag[a] >>= 1;
            end
            while (mx < (64'sd1 <<< 29)) begin
                mx <<= 1;
                for (int a = 0; a < 3; a++) mag[a] <<= 1;
            end
            sq = 0;
            for (int a = 0; a < 3; a++) sq += mag[a] * mag[a];
            len = root(sq);
            for (int a = 0; a < 3; a++) begin
                q = ((mag[a] << DIR_FRAC_BITS) + len / 2) / len;
                if (q > (1 << DIR_FRAC_BITS) - 1) q = (1 << DIR_FRAC_BITS) - 1;
                dir[a] = (dv[a] < 0) ? -longint'(q) : longint'(q);
            end
        end
        s.pos_x = COORD_BITS'(pos[0]);
        s.pos_y = COORD_BITS'(pos[1]);
        s.pos_z = COORD_BITS'(pos[2]);
        s.dir_x = Q_BITS'(dir[0]);
        s.dir_y = Q_BITS'(dir[1]);
        s.dir_z = Q_BITS'(dir[2]);
        pending.push_back(s);
    endfunction

    function void check_sample(t_curve_sample got);
        t_curve_sample e;
        if (pending.size() == 0) begin
            $error("unexpected result pos %0d %0d %0d", got.pos_x, got.pos_y, got.pos_z);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.pos_x !== e.pos_x) begin
            $error("pos_x expected %0d actual %0d", e.pos_x, got.pos_x); errors++;
        end
        if (got.pos_y !== e.pos_y) begin
            $error("pos_y expected %0d actual %0d", e.pos_y, got.pos_y); errors++;
        end
        if (got.pos_z !== e.pos_z) begin
            $error("pos_z expected %0d actual %0d", e.pos_z, got.pos_z); errors++;
        end
        if (got.dir_x !== e.dir_x) begin
            $error("dir_x expected %0d actual %0d", e.dir_x, got.dir_x); errors++;
        end
        if (got.dir_y !== e.dir_y) begin
            $error("dir_y expected %0d actual %0d", e.dir_y, got.dir_y); errors++;
        end
        if (got.dir_z !== e.dir_z) begin
            $error("dir_z expected %0d actual %0d", e.dir_z, got.dir_z); errors++;
        end
    endfunction
endclass

module cubic_bezier_position_tangent_tb;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]      i_cfg_index;
    logic [CFG_BITS-1:0]          i_cfg_data;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic signed [T_BITS-1:0]     i_param_t;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic signed [COORD_BITS-1:0] o_pos_x, o_pos_y, o_pos_z;
    logic signed [Q_BITS-1:0]     o_dir_x, o_dir_y, o_dir_z;

    curve_scoreboard sb;
    int  send_idle_pct;    // chance in 100 that the sender idles a cycle
    int  recv_stall_pct;   // chance in 100 that the receiver stalls a cycle
    int  hold_cycles;      // long output hold-off, counted down by the receiver

    cubic_bezier_position_tangent u_top (.*);

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_param_t = '0;
        i_out_stall = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        sb = new();
    end

    // Receiver: drive the stall and check each output transfer
    always @(posedge i_clk) begin
        t_curve_sample got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.pos_x = o_pos_x; got.pos_y = o_pos_y; got.pos_z = o_pos_z;
            got.dir_x = o_dir_x; got.dir_y = o_dir_y; got.dir_z = o_dir_z;
            sb.check_sample(got);
        end
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic logic [CFG_BITS-1:0] rand_point();
        logic [CFG_BITS-1:0] v;
        v = CFG_BITS'({$urandom, $urandom});
        // Keep small coordinates half the time so positions stay in range
        if ($urandom_range(1)) begin
            for (int a = 0; a < 3; a++)
                v[a*COORD_BITS +: COORD_BITS] = COORD_BITS'($signed(12'($urandom)));
        end
        return v;
    endfunction

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_point(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_points(logic [CFG_BITS-1:0] p0, logic [CFG_BITS-1:0] p1,
                               logic [CFG_BITS-1:0] p2, logic [CFG_BITS-1:0] p3);
        write_reg(REG_POINT0, p0);
        write_reg(REG_POINT1, p1);
        write_reg(REG_POINT2, p2);
        write_reg(REG_POINT3, p3);
    endtask

    // Offer one parameter; idle first at random, hold until the transfer
    task automatic send_param(logic signed [T_BITS-1:0] t);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_param_t  <= t;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_param(t);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic logic signed [T_BITS-1:0] rand_param();
        case ($urandom_range(9))
            0:       return T_BITS'($urandom);
            1:       return T_BITS'(T_ONE) + T_BITS'($urandom_range(3));
            2:       return T_BITS'($urandom_range(3));
            default: return T_BITS'($urandom_range(65536));
        endcase
    endfunction

    localparam logic [CFG_BITS-1:0] ALL_MAX = {3{COORD_MAX}};
    localparam logic [CFG_BITS-1:0] ALL_MIN = {3{COORD_MIN}};

    initial begin
        logic [CFG_BITS-1:0] p [4];
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero points: zero derivative, zero tangent
        send_param('0);
        send_param(T_BITS'(T_ONE));
        drain();

        // Directed: ends, clamping, extremes of the points, ignored index
        load_points(ALL_MIN, ALL_MAX, ALL_MIN, ALL_MAX);
        write_reg(8'hff, ALL_MAX);
        write_reg(8'd4, '0);
        foreach (p[i]) p[i] = '0;
        for (int i = 0; i < 10; i++) begin
            logic signed [T_BITS-1:0] dt [10];
            dt = '{18'sh20000, 18'sh3ffff, 18'sh1ffff, 18'sh10000, 18'sh10001,
                   18'sh00000, 18'sh00001, 18'sh08000, 18'sh0ffff, 18'sh15555};
            send_param(dt[i]);
        end
        drain();
        load_points(ALL_MAX, ALL_MAX, ALL_MAX, ALL_MAX);   // saturation, flat curve
        send_param(18'sh04000);
        send_param(18'sh0c000);
        drain();
        load_points(ALL_MIN, ALL_MIN, ALL_MAX, ALL_MAX);
        send_param(18'sh08000);
        send_param(18'sh00100);
        drain();

        // Random phases across idling profiles
        for (int ph = 0; ph < 10; ph++) begin
            foreach (p[i]) p[i] = rand_point();
            if (ph == 9) p[3] = p[0];
            load_points(p[0], p[1], p[2], p[3]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            if (ph == 4) hold_cycles = 300;   // fill the pipe and stall the input
            for (int i = 0; i < 200; i++) send_param(rand_param());
            drain();
        end
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("cubic_bezier_position_tangent_tb: PASS");
        end else begin
            $display("cubic_bezier_position_tangent_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("cubic_bezier_position_tangent_tb: FAIL");
        $finish;
    end

endmodule
